// ===== design/antialiased_disk_mask_top_defines.svh =====
// ----------------------------------------------------------------------------
// Antialiased disk mask - assertion macros
// Shared concurrent assertion forms for the disk mask checker.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_DISK_MASK_TOP_DEFINES_SVH
`define ANTIALIASED_DISK_MASK_TOP_DEFINES_SVH

// Check on every rising edge outside reset.
`define ADM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ADM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/adm_pkg.sv =====
// ----------------------------------------------------------------------------
// Antialiased disk mask - package
// Widths, pipeline geometry, register map and square root step.
// ----------------------------------------------------------------------------
package adm_pkg;

    localparam int COORD_BITS    = 12;
    localparam int CFG_W         = 16;
    localparam int PIX_W         = COORD_BITS + 4;
    localparam int DW            = (PIX_W > CFG_W) ? PIX_W : CFG_W;
    localparam int SQ_W          = 2 * DW + 1;
    localparam int RAD_W         = SQ_W + 8;
    localparam int ROOT_STEPS    = 2;
    localparam int SQRT_STAGES   = (RAD_W + 2 * ROOT_STEPS - 1) / (2 * ROOT_STEPS);
    localparam int ROOT_W        = SQRT_STAGES * ROOT_STEPS;
    localparam int RADP_W        = 2 * ROOT_W;
    localparam int REM_W         = ROOT_W + 2;
    localparam int RB_W          = CFG_W + 5;
    localparam int A_W           = ((RB_W > ROOT_W) ? RB_W : ROOT_W) + 1;
    localparam int PIPE_DEPTH    = SQRT_STAGES + 6;
    localparam int CNT_W         = $clog2(PIPE_DEPTH + 1);
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    // Fixed stage positions in the pipeline
    localparam int ST_IN    = 0;
    localparam int ST_DIFF  = 1;
    localparam int ST_SQ    = 2;
    localparam int ST_RAD   = 3;
    localparam int ST_SQRT0 = 4;
    localparam int ST_ALPHA = ST_SQRT0 + SQRT_STAGES;
    localparam int ST_OUT   = ST_ALPHA + 1;

    typedef enum logic [1:0] {
        REG_MASK_ENABLE = 2'd0,
        REG_CENTER_X    = 2'd1,
        REG_CENTER_Y    = 2'd2,
        REG_DISK_RADIUS = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_ZERO,
        MODE_SCALE
    } scale_mode_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic            bypass;
    } pix_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_st_t;

    // One restoring square root digit: bring down two radicand bits.
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t cur, input logic [1:0] pair);
        logic [REM_W:0] rem_sh;
        logic [REM_W:0] trial;
        sqrt_st_t       nxt;
        rem_sh = {cur.rem[REM_W-2:0], pair};
        trial  = {1'b0, cur.root, 2'b01};
        if (rem_sh >= trial)
        begin
            nxt.rem  = REM_W'(rem_sh - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = rem_sh[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ===== design/antialiased_disk_mask_top.sv =====
// ----------------------------------------------------------------------------
// Antialiased disk mask
// Crops a premultiplied pixel stream to a soft-edged disk.
// ----------------------------------------------------------------------------
// Each item is one 4-byte pixel with its column and row. The block measures
// the distance from the pixel centre to the configured disk centre, forms a
// coverage alpha of radius minus distance plus one half (Q.8, clamped 0..256)
// and then clears, passes or scales the four bytes with rounding half up.
// With the mask disabled, or a zero radius, pixels pass unchanged. The block
// takes one item per clock, unless a stall from the result side has backed
// it up, through PIPE_DEPTH register stages (17 at 12-bit coordinates):
// input capture, difference, square, sum, then the square root pipeline (11
// stages, two root bits per stage, which sets the latency), alpha and the
// output multiply. Stall from the result side holds only the stages that are
// full, so bubbles collapse and the pixel side keeps flowing while empty
// stages remain. Configuration is read straight from the registers, so write
// it only while no item is in flight.
module antialiased_disk_mask_top
    import adm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel side
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [COORD_BITS-1:0] column,
    input  logic [COORD_BITS-1:0] row,
    input  logic [7:0]            byte0_in,
    input  logic [7:0]            byte1_in,
    input  logic [7:0]            byte2_in,
    input  logic [7:0]            byte3_in,
    // result side
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [7:0]            byte0_out,
    output logic [7:0]            byte1_out,
    output logic [7:0]            byte2_out,
    output logic [7:0]            byte3_out,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic             mask_enable_reg;
    logic [CFG_W-1:0] center_x_reg;
    logic [CFG_W-1:0] center_y_reg;
    logic [CFG_W-1:0] disk_radius_reg;
    reg_idx_t         reg_idx;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_enable_reg <= 1'b0;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            disk_radius_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_MASK_ENABLE: mask_enable_reg <= pwdata[0];
                REG_CENTER_X:    center_x_reg    <= pwdata[CFG_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[CFG_W-1:0];
                REG_DISK_RADIUS: disk_radius_reg <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MASK_ENABLE: prdata = DATA_W'(mask_enable_reg);
            REG_CENTER_X:    prdata = DATA_W'(center_x_reg);
            REG_CENTER_Y:    prdata = DATA_W'(center_y_reg);
            REG_DISK_RADIUS: prdata = DATA_W'(disk_radius_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic valid_reg [PIPE_DEPTH];
    logic adv       [PIPE_DEPTH];
    pix_t pix_reg   [PIPE_DEPTH];

    always_comb
    begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !result_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign pixel_stall  = !adv[ST_IN];
    assign result_valid = valid_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (adv[ST_IN])
            begin
                valid_reg[ST_IN] <= pixel_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] row_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_IN])
        begin
            col_reg <= column;
            row_reg <= row;
        end
    end

    // ------------------------------------------------------------------
    // Absolute offsets from the disk centre, Q.4
    // ------------------------------------------------------------------
    logic [DW-1:0] px;
    logic [DW-1:0] py;
    logic [DW-1:0] cx;
    logic [DW-1:0] cy;
    logic [DW-1:0] dx_next;
    logic [DW-1:0] dy_next;
    logic [DW-1:0] dx_reg;
    logic [DW-1:0] dy_reg;

    always_comb
    begin
        // pixel centre is coordinate plus one half
        px      = DW'({col_reg, 4'd8});
        py      = DW'({row_reg, 4'd8});
        cx      = DW'(center_x_reg);
        cy      = DW'(center_y_reg);
        dx_next = (px >= cx) ? (px - cx) : (cx - px);
        dy_next = (py >= cy) ? (py - cy) : (cy - py);
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIFF])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // ------------------------------------------------------------------
    // Squares, then their sum as the root radicand (Q.8 shifted by 8)
    // ------------------------------------------------------------------
    logic [2*DW-1:0] sqx_reg;
    logic [2*DW-1:0] sqy_reg;
    logic [SQ_W-1:0] d2_next;

    always_ff @(posedge clk)
    begin
        if (adv[ST_SQ])
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
        end
    end

    assign d2_next = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    logic [RADP_W-1:0] rad_reg [SQRT_STAGES];
    sqrt_st_t          sq_reg  [SQRT_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (adv[ST_RAD])
        begin
            rad_reg[0]     <= RADP_W'({d2_next, 8'd0});
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Square root pipeline, ROOT_STEPS digits per stage
    // ------------------------------------------------------------------
    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        sqrt_st_t          st_next;
        logic [RADP_W-1:0] rad_next;

        always_comb
        begin
            st_next  = sq_reg[s];
            rad_next = rad_reg[s];
            for (int j = 0; j < ROOT_STEPS; j++)
            begin
                st_next  = sqrt_step(st_next, rad_next[RADP_W-1 -: 2]);
                rad_next = rad_next << 2;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[ST_SQRT0+s])
            begin
                sq_reg[s+1] <= st_next;
            end
        end

        if (s < SQRT_STAGES - 1)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (adv[ST_SQRT0+s])
                begin
                    rad_reg[s+1] <= rad_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Coverage alpha = radius*16 + 128 - distance, clamped
    // ------------------------------------------------------------------
    logic [RB_W-1:0]      rb;
    logic signed [A_W-1:0] a_val;
    scale_mode_t          mode_next;
    scale_mode_t          mode_reg;
    logic [7:0]           alpha_reg;

    always_comb
    begin
        rb    = {disk_radius_reg, 4'd0} + RB_W'(128);
        a_val = signed'(A_W'(rb)) - signed'(A_W'(sq_reg[SQRT_STAGES].root));
        if (pix_reg[ST_ALPHA-1].bypass)
        begin
            mode_next = MODE_PASS;
        end
        else if (a_val <= 0)
        begin
            mode_next = MODE_ZERO;
        end
        else if (a_val >= A_W'(256))
        begin
            mode_next = MODE_PASS;
        end
        else
        begin
            mode_next = MODE_SCALE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_ALPHA])
        begin
            mode_reg  <= mode_next;
            alpha_reg <= a_val[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Output: clear, pass or scale each byte with rounding half up
    // ------------------------------------------------------------------
    logic [3:0][7:0] out_next;
    logic [15:0]     prod;

    always_comb
    begin
        out_next = pix_reg[ST_ALPHA].bytes;
        prod     = '0;
        unique case (mode_reg)
            MODE_PASS:  out_next = pix_reg[ST_ALPHA].bytes;
            MODE_ZERO:  out_next = '0;
            MODE_SCALE:
            begin
                for (int b = 0; b < 4; b++)
                begin
                    prod        = 16'(pix_reg[ST_ALPHA].bytes[b]) * 16'(alpha_reg)
                                  + 16'd128;
                    out_next[b] = prod[15:8];
                end
            end
            default:    out_next = pix_reg[ST_ALPHA].bytes;
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel record: decide bypass once per item at capture, carry the
    // bytes along every stage, load the masked bytes at the output stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[ST_IN])
        begin
            pix_reg[ST_IN].bytes  <= {byte3_in, byte2_in, byte1_in, byte0_in};
            pix_reg[ST_IN].bypass <= !mask_enable_reg || (disk_radius_reg == '0);
        end
        for (int k = 1; k < ST_OUT; k++)
        begin
            if (adv[k])
            begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
        if (adv[ST_OUT])
        begin
            pix_reg[ST_OUT].bytes  <= out_next;
            pix_reg[ST_OUT].bypass <= pix_reg[ST_ALPHA].bypass;
        end
    end

    assign byte0_out = pix_reg[ST_OUT].bytes[0];
    assign byte1_out = pix_reg[ST_OUT].bytes[1];
    assign byte2_out = pix_reg[ST_OUT].bytes[2];
    assign byte3_out = pix_reg[ST_OUT].bytes[3];

endmodule

// ===== design/adm_checker.sv =====
// ----------------------------------------------------------------------------
// Antialiased disk mask - port checker
// Watches the item channels for flow and occupancy slips.
// ----------------------------------------------------------------------------
`include "antialiased_disk_mask_top_defines.svh"

module adm_checker
    import adm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] byte0_out,
    input logic [7:0] byte1_out,
    input logic [7:0] byte2_out,
    input logic [7:0] byte3_out
);

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] outstanding_reg;
    logic [CNT_W-1:0] outstanding_next;

    assign in_acc           = pixel_valid && !pixel_stall;
    assign out_acc          = result_valid && !result_stall;
    assign outstanding_next = outstanding_reg + CNT_W'(in_acc) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `ADM_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(byte0_out) && $stable(byte1_out) && $stable(byte2_out) && $stable(byte3_out), "stalled result item changed")
    `ADM_ASSERT_ALWAYS(a_no_backpressure, !result_stall |-> !pixel_stall, "pixel side stalled while result side is free")
    `ADM_ASSERT(a_no_phantom, result_valid |-> outstanding_reg != '0, "result item without a pixel item in flight")
    `ADM_ASSERT(a_bounded, outstanding_reg <= CNT_W'(PIPE_DEPTH), "more items in flight than pipeline stages")

endmodule

bind antialiased_disk_mask_top adm_checker u_adm_checker (.*);

// ===== dv/antialiased_disk_mask_top_test.sv =====
// ----------------------------------------------------------------------------
// Antialiased disk mask - testbench
// Streams pixels through the disk mask and checks every masked pixel.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the mask settings and predicts each
// masked pixel from the pixel's column, row and bytes. It clears, scales or
// passes the bytes exactly as the fixed point mask does. Predictions queue up
// in order and each returned pixel is compared byte by byte with the oldest.
// The settings walk from reset values, through a zero radius and the extremes
// of centre and radius, to random disks. Random pixels cluster round the disk
// rim so that the soft edge sees plenty of traffic. Both sides idle at random,
// and the result side twice holds off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module antialiased_disk_mask_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import adm_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 120;

    // ------------------------------------------------------------------------
    // Scoreboard: mask settings, masked pixel prediction and comparison
    // ------------------------------------------------------------------------
    class disk_mask_scoreboard;
        logic            enable;
        logic [15:0]     centre_x;
        logic [15:0]     centre_y;
        logic [15:0]     radius;
        logic [3:0][7:0] masked_q[$];
        int unsigned     accepted;
        int unsigned     checked;
        int unsigned     mismatches;
        int unsigned     n_passed;
        int unsigned     n_cleared;
        int unsigned     n_scaled;
        int unsigned     n_full;

        function new();
            enable   = 1'b0;
            centre_x = '0;
            centre_y = '0;
            radius   = '0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_MASK_ENABLE: enable   = value[0];
                REG_CENTER_X:    centre_x = value[15:0];
                REG_CENTER_Y:    centre_y = value[15:0];
                REG_DISK_RADIUS: radius   = value[15:0];
                default: ;
            endcase
        endfunction

        // Integer square root, truncated
        function logic [31:0] floor_root(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = '0;
            for (int k = 31; k >= 0; k--)
            begin
                t = r | (64'd1 << k);
                if (t * t <= v)
                    r = t;
            end
            return r[31:0];
        endfunction

        // Distance along one axis from pixel centre to disk centre, Q.4
        function logic [63:0] axis_gap(logic [COORD_BITS-1:0] pos, logic [15:0] ctr);
            logic [63:0] mid;
            logic [63:0] c;
            mid = 64'({pos, 4'h8});
            c   = 64'(ctr);
            return (mid >= c) ? mid - c : c - mid;
        endfunction

        function void note_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                                 logic [3:0][7:0] px);
            logic [63:0]     dx;
            logic [63:0]     dy;
            logic [31:0]     centre_gap;
            longint          alpha;
            logic [3:0][7:0] res;
            res = px;
            if (enable && radius != 0)
            begin
                dx         = axis_gap(col, centre_x);
                dy         = axis_gap(row, centre_y);
                centre_gap = floor_root((dx * dx + dy * dy) << 8);
                alpha      = longint'({radius, 4'h0}) + 128 - longint'(centre_gap);
                if (alpha <= 0)
                begin
                    res = '0;
                    n_cleared++;
                end
                else if (alpha < 256)
                begin
                    // scale with rounding half up
                    for (int i = 0; i < 4; i++)
                        res[i] = 8'((32'(px[i]) * 32'(alpha[8:0]) + 32'd128) >> 8);
                    n_scaled++;
                end
                else
                    n_full++;
            end
            else
                n_passed++;
            masked_q = {masked_q, res};
            accepted++;
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s at item %0d: expected %h, got %h",
                             what, checked, want, got);
            end
        endfunction

        function void check_result(logic [3:0][7:0] got);
            logic [3:0][7:0] want;
            if (masked_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("masked pixel %h arrived with nothing pending", got);
                return;
            end
            want = masked_q.pop_front();
            for (int i = 0; i < 4; i++)
                compare($sformatf("byte%0d_out", i), 32'(want[i]), 32'(got[i]));
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_stall;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [7:0]            byte0_in;
    logic [7:0]            byte1_in;
    logic [7:0]            byte2_in;
    logic [7:0]            byte3_in;
    logic                  result_valid;
    logic                  result_stall;
    logic [7:0]            byte0_out;
    logic [7:0]            byte1_out;
    logic [7:0]            byte2_out;
    logic [7:0]            byte3_out;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    disk_mask_scoreboard sb = new();
    bit                  sender_quiet;
    int unsigned         settings_seen;
    int unsigned         cycles;

    antialiased_disk_mask_top dut (.*);

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Idle run length: mostly short, now and then long
    function automatic int unsigned run_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(3, 1);
        else if (roll < 95)
            return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    // ------------------------------------------------------------------------
    // Pixel side
    // ------------------------------------------------------------------------
    // Offer one item and return at the edge that takes it. Valid stays high
    // into the next call, so back-to-back items need no extra assignment.
    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] rw,
                              input logic [3:0][7:0] px);
        int unsigned gap;
        gap = (!sender_quiet && $urandom_range(2) == 0) ? run_len() : 0;
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        column      <= col;
        row         <= rw;
        byte0_in    <= px[0];
        byte1_in    <= px[1];
        byte2_in    <= px[2];
        byte3_in    <= px[3];
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        sb.note_pixel(col, rw, px);
    endtask

    // Random pixels, most of them within a few pixels of the disk so that
    // the rim is crossed often; the rest anywhere or on the frame corners.
    task automatic random_pixels(input int unsigned count);
        int              reach;
        int              ctr_col;
        int              ctr_row;
        int              col;
        int              rw;
        int unsigned     roll;
        logic [3:0][7:0] px;
        reach   = int'(sb.radius >> 4) + 3;
        ctr_col = int'(sb.centre_x >> 4);
        ctr_row = int'(sb.centre_y >> 4);
        for (int n = 0; n < int'(count); n++)
        begin
            // switch between gappy and back-to-back stretches
            if (n % 64 == 0)
                sender_quiet = ($urandom_range(3) == 0);
            roll = $urandom_range(9);
            if (roll < 6)
            begin
                col = ctr_col + int'($urandom_range(2 * reach)) - reach;
                rw  = ctr_row + int'($urandom_range(2 * reach)) - reach;
            end
            else if (roll < 9)
            begin
                col = $urandom_range(COORD_MAX);
                rw  = $urandom_range(COORD_MAX);
            end
            else
            begin
                col = $urandom_range(1) ? COORD_MAX : 0;
                rw  = $urandom_range(1) ? COORD_MAX : 0;
            end
            if (col < 0)
                col = 0;
            else if (col > COORD_MAX)
                col = COORD_MAX;
            if (rw < 0)
                rw = 0;
            else if (rw > COORD_MAX)
                rw = COORD_MAX;
            px = $urandom();
            if ($urandom_range(9) == 0)
                for (int i = 0; i < 4; i++)
                    px[i] = $urandom_range(1) ? 8'hFF : 8'h00;
            send_pixel(COORD_BITS'(col), COORD_BITS'(rw), px);
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    // Write one register, then read it back. Upper data bits carry noise,
    // which the register must drop. psel stays high into the next call.
    task automatic cfg_write(input reg_idx_t idx, input logic [15:0] value);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] kept;
        word = {16'($urandom()), value};
        kept = (idx == REG_MASK_ENABLE) ? DATA_W'(value[0]) : DATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, kept);
        // read back: hold psel, drop penable for the setup cycle
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.compare($sformatf("register %s readback", idx.name()), kept, prdata);
    endtask

    // Let every pending pixel drain, then load a new set of mask settings
    task automatic configure(input logic en, input logic [15:0] cx,
                             input logic [15:0] cy, input logic [15:0] rad);
        pixel_valid <= 1'b0;
        while (sb.masked_q.size() != 0)
            @(posedge clk);
        cfg_write(REG_MASK_ENABLE, {15'($urandom()), en});
        cfg_write(REG_CENTER_X, cx);
        cfg_write(REG_CENTER_Y, cy);
        cfg_write(REG_DISK_RADIUS, rad);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_seen++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, with two long hold-offs
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int unsigned stall_left;
        int unsigned mode_left;
        int unsigned holds_done;
        bit          quiet;
        stall_left   = 0;
        mode_left    = 0;
        holds_done   = 0;
        quiet        = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < 2 && sb.accepted >= ((holds_done == 0) ? 300 : 700))
            begin
                // hold off long enough for the pipeline to fill and push back
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                stall_left = 0;
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    quiet     = ($urandom_range(3) == 0);
                    mode_left = $urandom_range(300, 50);
                end
                mode_left--;
                if (stall_left != 0)
                begin
                    stall_left--;
                    result_stall <= 1'b1;
                end
                else if (!quiet && $urandom_range(5) == 0)
                begin
                    stall_left   = run_len() - 1;
                    result_stall <= 1'b1;
                end
                else
                    result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result({byte3_out, byte2_out, byte1_out, byte0_out});

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("cycle limit of %0d reached with %0d pixels pending",
                 CYCLE_LIMIT, sb.masked_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        column       = '0;
        row          = '0;
        byte0_in     = '0;
        byte1_in     = '0;
        byte2_in     = '0;
        byte3_in     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        sender_quiet = 1'b0;
        settings_seen = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: mask off, pixels pass unchanged
        send_pixel('0, '0, 32'h0000_0000);
        send_pixel(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'('h5A5), COORD_BITS'('hA5A), 32'h55AA_0FF0);

        // Mask on but zero radius: still a pass-through
        configure(1'b1, 16'h0000, 16'h0000, 16'h0000);
        send_pixel('0, '0, 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(COORD_MAX), '0, 32'h1234_5678);
        random_pixels(40);

        // Disk at (100.5, 100.0), radius 10.5: centre, rim and far corners
        configure(1'b1, 16'h0648, 16'h0640, 16'h00A8);
        send_pixel(COORD_BITS'(100), COORD_BITS'(100), 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(110), COORD_BITS'(100), 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(110), COORD_BITS'(100), 32'hFF80_0100);
        send_pixel(COORD_BITS'(111), COORD_BITS'(100), 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(90), COORD_BITS'(100), 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(100), COORD_BITS'(110), 32'h8080_8080);
        send_pixel(COORD_BITS'(100), COORD_BITS'(89), 32'h12EF_CDAB);
        send_pixel('0, '0, 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 32'hFFFF_FFFF);
        send_pixel(COORD_BITS'(COORD_MAX), '0, 32'hFFFF_FFFF);
        send_pixel('0, COORD_BITS'(COORD_MAX), 32'hFFFF_FFFF);
        random_pixels(180);

        // Largest centre and radius
        configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 32'hFFFF_FFFF);
        random_pixels(150);

        // Smallest radius at the origin
        configure(1'b1, 16'h0000, 16'h0000, 16'h0001);
        send_pixel('0, '0, 32'hFFFF_FFFF);
        random_pixels(60);

        // Mask off with a live disk
        configure(1'b0, 16'($urandom()), 16'($urandom()), 16'($urandom_range(65535, 1)));
        random_pixels(60);

        // Random disks, mostly small, now and then any size
        repeat (4)
        begin
            configure(1'b1, 16'($urandom()), 16'($urandom()),
                      ($urandom_range(9) < 7) ? 16'($urandom_range(1024, 16))
                                              : 16'($urandom()));
            random_pixels(135);
        end

        // Drain, then wait out the pipeline for any stray result
        pixel_valid <= 1'b0;
        while (sb.masked_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("%0d pixels over %0d mask settings: %0d full, %0d rim-scaled, %0d cleared,",
                 sb.accepted, settings_seen, sb.n_full, sb.n_scaled, sb.n_cleared);
        $display("%0d passed through; %0d checked, %0d mismatches in %0d cycles",
                 sb.n_passed, sb.checked, sb.mismatches, cycles);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
